@@ src/mtc_pkg.sv @@
// ----------------------------------------------------------------------------
// Minnaert terrain correction package
// Shared types, constants, lookup tables and rounding helpers.
// ----------------------------------------------------------------------------
package mtc_pkg;

  typedef logic signed [43:0] vec_t;
  typedef logic signed [20:0] ang_t;
  typedef logic signed [33:0] rot_t;

  typedef struct packed {
    logic [15:0] pix;
    logic        in_dem;
    logic        cineg;
    logic        czneg;
  } side_t;

  localparam logic [2:0] CFG_ZENITH  = 3'd0;
  localparam logic [2:0] CFG_AZIMUTH = 3'd1;
  localparam logic [2:0] CFG_K       = 3'd2;
  localparam logic [2:0] CFG_STEP_X  = 3'd3;
  localparam logic [2:0] CFG_STEP_Y  = 3'd4;

  localparam logic [1:0] ST_CORRECTED = 2'd0;
  localparam logic [1:0] ST_OUTSIDE   = 2'd1;
  localparam logic [1:0] ST_DARK      = 2'd2;

  localparam ang_t HALF_PI = 21'sd102944;
  localparam ang_t PI      = 21'sd205887;
  localparam ang_t TWO_PI  = 21'sd411775;
  localparam ang_t FOUR_PI = 21'sd823550;
  localparam ang_t THREE_PI_LIM = 21'sd617662;
  localparam rot_t CORDIC_START = 34'sd652032874;
  localparam logic [16:0] INV_GAIN = 17'd39797;
  localparam logic [19:0] OUT_MAX = 20'hFFFFF;

  function automatic ang_t atan_q16(input int i);
    ang_t r;
    case (i)
      0: r = 21'sd51472;
      1: r = 21'sd30386;
      2: r = 21'sd16055;
      3: r = 21'sd8150;
      4: r = 21'sd4091;
      5: r = 21'sd2047;
      6: r = 21'sd1024;
      7: r = 21'sd512;
      8: r = 21'sd256;
      9: r = 21'sd128;
      10: r = 21'sd64;
      11: r = 21'sd32;
      12: r = 21'sd16;
      13: r = 21'sd8;
      14: r = 21'sd4;
      default: r = 21'sd2;
    endcase
    return r;
  endfunction

  function automatic logic [21:0] exp2_q20(input int i);
    logic [21:0] r;
    case (i)
      0: r = 22'd1482910;
      1: r = 22'd1246974;
      2: r = 22'd1143480;
      3: r = 22'd1095000;
      4: r = 22'd1071537;
      5: r = 22'd1059994;
      6: r = 22'd1054270;
      7: r = 22'd1051419;
      8: r = 22'd1049997;
      9: r = 22'd1049286;
      10: r = 22'd1048931;
      11: r = 22'd1048753;
      12: r = 22'd1048665;
      13: r = 22'd1048620;
      14: r = 22'd1048598;
      default: r = 22'd1048587;
    endcase
    return r;
  endfunction

  // Rescale a product by 2^-sh, rounding half away from zero.
  function automatic logic signed [71:0] rnd(input logic signed [71:0] p, input int sh);
    logic [71:0] mag;
    logic [71:0] r;
    mag = p[71] ? 72'(-p) : 72'(p);
    r = (mag + (72'(1) << (sh - 1))) >> sh;
    return p[71] ? -$signed(r) : $signed(r);
  endfunction

  // Bring an angle into (-pi, pi].
  function automatic ang_t wrap(input ang_t th);
    ang_t r;
    if (th > THREE_PI_LIM) begin
      r = th - FOUR_PI;
    end else if (th > PI) begin
      r = th - TWO_PI;
    end else if (th <= -PI) begin
      r = th + TWO_PI;
    end else begin
      r = th;
    end
    return r;
  endfunction

endpackage

@@ src/minnaert_terrain_correction.sv @@
// ----------------------------------------------------------------------------
// Minnaert terrain correction
// Per pixel slope, aspect and illumination from four DEM neighbors, then
// scaling of the sample by (cos z / cos i)^K with saturation.
// Throughput is one pixel per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module minnaert_terrain_correction (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_value, height_row_prev, height_row_next, height_col_prev,
  // height_col_next
  input  logic [95:0] s_axis_tdata,
  // inside_dem
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // corrected_value, zero padding
  output logic [23:0] m_axis_tdata,
  // status, saturated
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [13:0] zenith_angle;
  logic [15:0] azimuth_angle;
  logic [15:0] minnaert_k;
  logic [15:0] grid_step_x;
  logic [15:0] grid_step_y;

  logic adv;
  logic vld [1:103];
  mtc_pkg::side_t sd [1:102];

  // Stage 1 to 4: gradients and normalization.
  logic signed [20:0] dr, dc;
  logic [15:0] sx, sy;
  logic signed [37:0] u, v;
  logic [33:0] w;
  logic signed [37:0] u3, v3;
  logic [33:0] w3;
  logic [5:0] nsh;
  logic [37:0] orv;
  logic [5:0] msb3;

  // Aspect vectoring.
  mtc_pkg::vec_t vx [0:16];
  mtc_pkg::vec_t vy [0:16];
  mtc_pkg::ang_t va [0:16];
  logic [39:0] vw [0:16];
  logic vu0 [0:16];
  logic vneg [0:16];
  logic signed [39:0] un, vn;

  mtc_pkg::ang_t a21, a22;
  logic signed [60:0] magp;
  logic [39:0] w21;
  mtc_pkg::vec_t mag;
  logic [39:0] w22;

  // Slope vectoring.
  mtc_pkg::vec_t sxv [0:16];
  mtc_pkg::vec_t syv [0:16];
  mtc_pkg::ang_t sa [0:16];
  mtc_pkg::ang_t ad [0:16];

  // Sine and cosine lanes: zenith, slope, azimuth minus aspect.
  mtc_pkg::ang_t th39 [3];
  mtc_pkg::rot_t rx [3][0:16];
  mtc_pkg::rot_t ry [3][0:16];
  mtc_pkg::ang_t rt [3][0:16];
  logic [2:0] rf [0:16];

  mtc_pkg::rot_t cz, sz, cs, ss, ca;
  logic signed [67:0] p1, p2, p3;
  mtc_pkg::rot_t cz58, ca58, cz59, ca59, cz60, cz61;
  logic signed [34:0] r1, r2, r1b, r1c, r3;
  logic signed [34:0] cosi;
  mtc_pkg::rot_t cz62;

  // log2 lanes: cos z and cos i.
  logic [34:0] lx [2];
  logic [5:0] msb63 [2];
  logic [30:0] lm [2][0:16];
  logic [15:0] lf [2][0:16];
  logic signed [6:0] lpe [2][0:16];
  logic [31:0] sqt [2][0:15];

  logic signed [23:0] dif;
  logic signed [40:0] ep;
  logic signed [10:0] en [0:16];
  logic [15:0] ef [0:16];
  logic [21:0] em [0:16];

  logic [37:0] pp;
  logic signed [11:0] psh;
  logic [19:0] lv;
  logic lsat;
  logic [39:0] rv;
  logic pzero, shneg;
  logic [57:0] pl;
  logic [11:0] sneg;
  logic [5:0] sr;
  logic [4:0] lamt;

  logic [19:0] out_val;
  logic [1:0] out_st;
  logic out_sat;

  assign adv = !vld[103] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[103];
  assign m_axis_tdata = {4'd0, out_val};
  assign m_axis_tuser = {out_sat, out_st};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zenith_angle <= '0;
      azimuth_angle <= '0;
      minnaert_k <= 16'd16384;
      grid_step_x <= 16'd240;
      grid_step_y <= 16'd240;
    end else if (cfg_valid) begin
      case (cfg_index)
        mtc_pkg::CFG_ZENITH: zenith_angle <= cfg_data[13:0];
        mtc_pkg::CFG_AZIMUTH: azimuth_angle <= cfg_data;
        mtc_pkg::CFG_K: minnaert_k <= cfg_data;
        mtc_pkg::CFG_STEP_X: grid_step_x <= cfg_data;
        mtc_pkg::CFG_STEP_Y: grid_step_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 103; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= 103; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    orv = (u[37] ? 38'(-u) : 38'(u)) | (v[37] ? 38'(-v) : 38'(v)) | 38'(w);
    msb3 = '0;
    for (int b = 0; b < 38; b++) begin
      if (orv[b]) begin
        msb3 = 6'(b);
      end
    end
    un = 40'(u3) <<< nsh;
    vn = 40'(v3) <<< nsh;
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      msb63[l] = '0;
      for (int b = 0; b < 35; b++) begin
        if (lx[l][b]) begin
          msb63[l] = 6'(b);
        end
      end
      for (int j = 0; j < 16; j++) begin
        sqt[l][j] = 32'((62'(lm[l][j]) * 62'(lm[l][j])) >> 30);
      end
    end
  end

  always_comb begin
    lamt = (psh > 12'sd20) ? 5'd0 : psh[4:0];
    pl = 58'(pp) << lamt;
    sneg = 12'(-psh);
    sr = (sneg > 12'd40) ? 6'd40 : sneg[5:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1.
      sd[1].pix <= s_axis_tdata[15:0];
      sd[1].in_dem <= s_axis_tuser;
      sd[1].cineg <= 1'b0;
      sd[1].czneg <= 1'b0;
      for (int k = 2; k <= 102; k++) begin
        if (k != 63) begin
          sd[k] <= sd[k-1];
        end
      end
      dr <= {s_axis_tdata[55], s_axis_tdata[55:36]} - {s_axis_tdata[35], s_axis_tdata[35:16]};
      dc <= {s_axis_tdata[95], s_axis_tdata[95:76]} - {s_axis_tdata[75], s_axis_tdata[75:56]};
      sx <= (grid_step_x == 16'd0) ? 16'd1 : grid_step_x;
      sy <= (grid_step_y == 16'd0) ? 16'd1 : grid_step_y;

      // Stage 2.
      u <= dr * $signed({1'b0, sy});
      v <= dc * $signed({1'b0, sx});
      w <= (34'(sx) * 34'(sy)) << 1;

      // Stage 3.
      u3 <= u;
      v3 <= v;
      w3 <= w;
      nsh <= 6'd38 - msb3;

      // Stage 4.
      vx[0] <= un[39] ? 44'(-un) : 44'(un);
      vy[0] <= un[39] ? 44'(-vn) : 44'(vn);
      va[0] <= '0;
      vw[0] <= 40'(w3) << nsh;
      vu0[0] <= (u3 == 38'sd0);
      vneg[0] <= vn[39];

      for (int i = 0; i < 16; i++) begin
        if (vy[i] >= 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          va[i+1] <= va[i] + mtc_pkg::atan_q16(i);
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          va[i+1] <= va[i] - mtc_pkg::atan_q16(i);
        end
        vw[i+1] <= vw[i];
        vu0[i+1] <= vu0[i];
        vneg[i+1] <= vneg[i];
      end

      // Stage 21 and 22: aspect and corrected magnitude.
      if (vu0[16]) begin
        a21 <= vneg[16] ? -mtc_pkg::HALF_PI : mtc_pkg::HALF_PI;
      end else begin
        a21 <= va[16];
      end
      magp <= 61'(vx[16]) * $signed({44'd0, mtc_pkg::INV_GAIN});
      w21 <= vw[16];
      mag <= 44'(mtc_pkg::rnd(72'(magp), 16));
      w22 <= w21;
      a22 <= a21;

      // Slope vectoring.
      sxv[0] <= 44'(w22);
      syv[0] <= mag;
      sa[0] <= '0;
      ad[0] <= a22;
      for (int i = 0; i < 16; i++) begin
        if (syv[i] >= 0) begin
          sxv[i+1] <= sxv[i] + (syv[i] >>> i);
          syv[i+1] <= syv[i] - (sxv[i] >>> i);
          sa[i+1] <= sa[i] + mtc_pkg::atan_q16(i);
        end else begin
          sxv[i+1] <= sxv[i] - (syv[i] >>> i);
          syv[i+1] <= syv[i] + (sxv[i] >>> i);
          sa[i+1] <= sa[i] - mtc_pkg::atan_q16(i);
        end
        ad[i+1] <= ad[i];
      end

      // Stage 40: wrap, stage 41: fold into the right half plane.
      th39[0] <= mtc_pkg::wrap(21'({zenith_angle, 3'b000}));
      th39[1] <= mtc_pkg::wrap(sa[16]);
      th39[2] <= mtc_pkg::wrap(21'({azimuth_angle, 3'b000}) - ad[16]);
      for (int l = 0; l < 3; l++) begin
        rx[l][0] <= mtc_pkg::CORDIC_START;
        ry[l][0] <= '0;
        if (th39[l] > mtc_pkg::HALF_PI) begin
          rt[l][0] <= th39[l] - mtc_pkg::PI;
          rf[0][l] <= 1'b1;
        end else if (th39[l] < -mtc_pkg::HALF_PI) begin
          rt[l][0] <= th39[l] + mtc_pkg::PI;
          rf[0][l] <= 1'b1;
        end else begin
          rt[l][0] <= th39[l];
          rf[0][l] <= 1'b0;
        end
        for (int i = 0; i < 16; i++) begin
          if (rt[l][i] >= 0) begin
            rx[l][i+1] <= rx[l][i] - (ry[l][i] >>> i);
            ry[l][i+1] <= ry[l][i] + (rx[l][i] >>> i);
            rt[l][i+1] <= rt[l][i] - mtc_pkg::atan_q16(i);
          end else begin
            rx[l][i+1] <= rx[l][i] + (ry[l][i] >>> i);
            ry[l][i+1] <= ry[l][i] - (rx[l][i] >>> i);
            rt[l][i+1] <= rt[l][i] + mtc_pkg::atan_q16(i);
          end
        end
      end
      for (int i = 0; i < 16; i++) begin
        rf[i+1] <= rf[i];
      end

      // Stage 58.
      cz <= rf[16][0] ? -rx[0][16] : rx[0][16];
      sz <= rf[16][0] ? -ry[0][16] : ry[0][16];
      cs <= rf[16][1] ? -rx[1][16] : rx[1][16];
      ss <= rf[16][1] ? -ry[1][16] : ry[1][16];
      ca <= rf[16][2] ? -rx[2][16] : rx[2][16];

      // Stage 59 to 63: cos i.
      p1 <= 68'(cz) * 68'(cs);
      p2 <= 68'(ss) * 68'(sz);
      cz58 <= cz;
      ca58 <= ca;
      r1 <= 35'(mtc_pkg::rnd(72'(p1), 30));
      r2 <= 35'(mtc_pkg::rnd(72'(p2), 30));
      cz59 <= cz58;
      ca59 <= ca58;
      p3 <= 68'(r2) * 68'(ca59);
      r1b <= r1;
      cz60 <= cz59;
      r3 <= 35'(mtc_pkg::rnd(72'(p3), 30));
      r1c <= r1b;
      cz61 <= cz60;
      cosi <= r1c + r3;
      cz62 <= cz61;
      sd[63].pix <= sd[62].pix;
      sd[63].in_dem <= sd[62].in_dem;
      sd[63].cineg <= (r1c + r3) <= 35'sd0;
      sd[63].czneg <= cz61 <= 34'sd0;

      // Stage 64 and 65: leading bit and mantissa.
      lx[0] <= 35'(cz62);
      lx[1] <= 35'(cosi);
      for (int l = 0; l < 2; l++) begin
        if (msb63[l] > 6'd30) begin
          lm[l][0] <= 31'(lx[l] >> (msb63[l] - 6'd30));
        end else begin
          lm[l][0] <= 31'(lx[l] << (6'd30 - msb63[l]));
        end
        lf[l][0] <= '0;
        lpe[l][0] <= $signed({1'b0, msb63[l]}) - 7'sd30;
        for (int j = 0; j < 16; j++) begin
          if (sqt[l][j][31]) begin
            lm[l][j+1] <= sqt[l][j][31:1];
            lf[l][j+1] <= {lf[l][j][14:0], 1'b1};
          end else begin
            lm[l][j+1] <= sqt[l][j][30:0];
            lf[l][j+1] <= {lf[l][j][14:0], 1'b0};
          end
          lpe[l][j+1] <= lpe[l][j];
        end
      end

      // Stage 82 to 84: exponent.
      dif <= {lpe[0][16][6], lpe[0][16], lf[0][16]} - {lpe[1][16][6], lpe[1][16], lf[1][16]};
      ep <= $signed({1'b0, minnaert_k}) * dif;
      en[0] <= 11'(mtc_pkg::rnd(72'(ep), 14) >>> 16);
      ef[0] <= 16'(mtc_pkg::rnd(72'(ep), 14));
      em[0] <= 22'd1048576;
      for (int k = 0; k < 16; k++) begin
        if (ef[k][15-k]) begin
          em[k+1] <= 22'((44'(em[k]) * 44'(mtc_pkg::exp2_q20(k)) + 44'd524288) >> 20);
        end else begin
          em[k+1] <= em[k];
        end
        ef[k+1] <= ef[k];
        en[k+1] <= en[k];
      end

      // Stage 101 to 103: scale, shift and saturate.
      pp <= 38'(sd[100].pix) * 38'(em[16]);
      psh <= $signed({en[16][10], en[16]}) - 12'sd16;
      pzero <= (pp == 38'd0);
      shneg <= psh[11];
      lv <= pl[19:0];
      lsat <= (psh > 12'sd20) || (pl[57:20] != 38'd0);
      rv <= (40'(pp) + (40'd1 << (sr - 6'd1))) >> sr;

      if (!sd[102].in_dem) begin
        out_val <= {sd[102].pix, 4'd0};
        out_st <= mtc_pkg::ST_OUTSIDE;
        out_sat <= 1'b0;
      end else if (sd[102].cineg) begin
        out_val <= {sd[102].pix, 4'd0};
        out_st <= mtc_pkg::ST_DARK;
        out_sat <= 1'b0;
      end else if (sd[102].czneg) begin
        out_val <= (minnaert_k == 16'd0) ? {sd[102].pix, 4'd0} : 20'd0;
        out_st <= mtc_pkg::ST_CORRECTED;
        out_sat <= 1'b0;
      end else begin
        out_st <= mtc_pkg::ST_CORRECTED;
        if (pzero) begin
          out_val <= 20'd0;
          out_sat <= 1'b0;
        end else if (!shneg) begin
          out_val <= lsat ? mtc_pkg::OUT_MAX : lv;
          out_sat <= lsat;
        end else if (rv > 40'(mtc_pkg::OUT_MAX)) begin
          out_val <= mtc_pkg::OUT_MAX;
          out_sat <= 1'b1;
        end else begin
          out_val <= rv[19:0];
          out_sat <= 1'b0;
        end
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Minnaert terrain correction testbench
// Streams pixels with DEM neighborhoods through the block under several
// register settings. A bit-exact predictor queues the expected corrected
// value, status and saturation flag for each accepted request, and a checker
// compares every result against the oldest entry. Both stream sides idle at
// random, and the output is once held off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT = 600000;

  typedef struct packed {
    logic               in_dem;
    logic signed [19:0] col_next;
    logic signed [19:0] col_prev;
    logic signed [19:0] row_next;
    logic signed [19:0] row_prev;
    logic [15:0]        pix;
  } pixel_t;

  typedef struct packed {
    logic [19:0] value;
    logic [1:0]  status;
    logic        sat;
  } corr_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  corr_t       expected_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          out_gap;
  int          hold_left;
  bit          hold_req;
  bit          burst;

  logic [13:0] zenith;
  logic [15:0] azimuth;
  logic [15:0] k_exp;
  logic [15:0] step_x;
  logic [15:0] step_y;

  longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
  longint unsigned exp2_tab[16] = '{1482910, 1246974, 1143480, 1095000, 1071537,
                                    1059994, 1054270, 1051419, 1049997, 1049286,
                                    1048931, 1048753, 1048665, 1048620, 1048598,
                                    1048587};

  minnaert_terrain_correction uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint mul_round(longint a, longint b, int sh);
    longint unsigned ua, ub, p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint vector_angle(inout longint x, inout longint y);
    longint ang, nx;
    ang = 0;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); ang += atan_tab[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); ang -= atan_tab[i];
      end
      x = nx;
    end
    return ang;
  endfunction

  function automatic void sin_cos(input longint th, output longint c, output longint s);
    longint x, y, nx;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    while (th > 205887) th -= 411775;
    while (th <= -205887) th += 411775;
    if (th > 102944) begin
      th -= 205887; flip = 1;
    end else if (th < -102944) begin
      th += 205887; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (th >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); th -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); th += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint log2_fixed(longint xv);
    longint unsigned m, ux;
    int p;
    longint fr;
    ux = xv;
    p = 0;
    fr = 0;
    while (p < 62 && (ux >> (p + 1)) != 0) p++;
    m = p > 30 ? ux >> (p - 30) : ux << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1; fr = fr | 1;
      end
    end
    return longint'(p - 30) * 65536 + fr;
  endfunction

  function automatic corr_t correct_pixel(pixel_t px);
    corr_t r;
    longint sx, sy, u, v, w, x, y, au, av, a_ang, s_ang, mag;
    longint cz, sz, cs, ss, ca, sa, cosi, e, n, f, sh;
    longint unsigned val, m, p;
    r.sat = 0;
    r.status = mtc_pkg::ST_OUTSIDE;
    val = longint'(px.pix) << 4;
    if (px.in_dem) begin
      sx = step_x != 0 ? step_x : 1;
      sy = step_y != 0 ? step_y : 1;
      u = (longint'(px.row_next) - longint'(px.row_prev)) * sy;
      v = (longint'(px.col_next) - longint'(px.col_prev)) * sx;
      w = 2 * sx * sy;
      forever begin
        au = u < 0 ? -u : u;
        av = v < 0 ? -v : v;
        if (au >= (64'sd1 <<< 38) || av >= (64'sd1 <<< 38) || w >= (64'sd1 <<< 38)) break;
        u *= 2; v *= 2; w *= 2;
      end
      x = u;
      y = v;
      if (x < 0) begin
        x = -x; y = -y;
      end
      a_ang = vector_angle(x, y);
      if (u == 0) a_ang = v >= 0 ? 102944 : -102944;
      mag = mul_round(x, 39797, 16);
      x = w;
      y = mag;
      s_ang = vector_angle(x, y);
      sin_cos(longint'(zenith) * 8, cz, sz);
      sin_cos(s_ang, cs, ss);
      sin_cos(longint'(azimuth) * 8 - a_ang, ca, sa);
      cosi = mul_round(cz, cs, 30) + mul_round(mul_round(ss, sz, 30), ca, 30);
      if (cosi <= 0) begin
        r.status = mtc_pkg::ST_DARK;
      end else begin
        r.status = mtc_pkg::ST_CORRECTED;
        if (cz <= 0) begin
          val = k_exp != 0 ? 0 : longint'(px.pix) << 4;
        end else begin
          e = mul_round(longint'(k_exp), log2_fixed(cz) - log2_fixed(cosi), 14);
          n = e >>> 16;
          f = e - n * 65536;
          m = 64'd1 << 20;
          sh = n - 16;
          for (int i = 0; i < 16; i++)
            if ((f >> (15 - i)) & 1) m = (m * exp2_tab[i] + (64'd1 << 19)) >> 20;
          p = longint'(px.pix) * m;
          if (p == 0) begin
            val = 0;
          end else if (sh >= 0) begin
            if (sh > 20 || p > (64'd1048575 >> sh)) begin
              val = 1048575; r.sat = 1;
            end else begin
              val = p << sh;
            end
          end else if (sh < -62) begin
            val = 0;
          end else begin
            val = (p + (64'd1 << (-sh - 1))) >> (-sh);
            if (val > 1048575) begin
              val = 1048575; r.sat = 1;
            end
          end
        end
      end
    end
    r.value = val[19:0];
    return r;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    corr_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      out_gap = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d status %0d", m_axis_tdata[19:0],
               m_axis_tuser[1:0]);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata[19:0] !== exp_r.value) begin
          $error("corrected_value: expected %0d, actual %0d", exp_r.value,
                 m_axis_tdata[19:0]);
          errors++;
        end
        if (m_axis_tuser[1:0] !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_axis_tuser[1:0]);
          errors++;
        end
        if (m_axis_tuser[2] !== exp_r.sat) begin
          $error("saturated: expected %0d, actual %0d", exp_r.sat, m_axis_tuser[2]);
          errors++;
        end
      end
    end
  end

  // Output ready, with random stalls and an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 0;
      hold_left--;
    end else if (out_gap > 0) begin
      m_axis_tready <= 0;
      out_gap--;
    end else begin
      m_axis_tready <= 1;
    end
  end

  task automatic send_pixel(pixel_t px);
    int w;
    w = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (w > 0) begin
      s_axis_tvalid <= 0;
      repeat (w) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {px.col_next, px.col_prev, px.row_next, px.row_prev, px.pix};
    s_axis_tuser <= px.in_dem;
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    expected_q.push_back(correct_pixel(px));
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (expected_q.size() > 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      mtc_pkg::CFG_ZENITH:  zenith = data[13:0];
      mtc_pkg::CFG_AZIMUTH: azimuth = data;
      mtc_pkg::CFG_K:       k_exp = data;
      mtc_pkg::CFG_STEP_X:  step_x = data;
      mtc_pkg::CFG_STEP_Y:  step_y = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] z, logic [15:0] az, logic [15:0] k,
                            logic [15:0] sx, logic [15:0] sy);
    drain();
    write_reg(mtc_pkg::CFG_ZENITH, z);
    write_reg(mtc_pkg::CFG_AZIMUTH, az);
    write_reg(mtc_pkg::CFG_K, k);
    write_reg(mtc_pkg::CFG_STEP_X, sx);
    write_reg(mtc_pkg::CFG_STEP_Y, sy);
    cfg_valid <= 0;
  endtask

  function automatic pixel_t make_pixel(logic [15:0] pix, int rp, int rn, int cp, int cn,
                                        logic in_dem);
    pixel_t px;
    px.pix = pix;
    px.row_prev = 20'(rp);
    px.row_next = 20'(rn);
    px.col_prev = 20'(cp);
    px.col_next = 20'(cn);
    px.in_dem = in_dem;
    return px;
  endfunction

  // Mostly smooth terrain around a random base; sometimes raw noise.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int base, spread;
    px = 97'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 9) < 8) begin
      base = $signed($urandom_range(0, 1048575)) - 524288;
      base = base / 2;
      spread = 1 << $urandom_range(0, 12);
      px.row_prev = 20'(base + $signed($urandom_range(0, 2 * spread)) - spread);
      px.row_next = 20'(base + $signed($urandom_range(0, 2 * spread)) - spread);
      px.col_prev = 20'(base + $signed($urandom_range(0, 2 * spread)) - spread);
      px.col_next = 20'(base + $signed($urandom_range(0, 2 * spread)) - spread);
      px.in_dem = $urandom_range(0, 9) != 0;
    end
    return px;
  endfunction

  task automatic test_directed;
    send_pixel(make_pixel(16'd0, 0, 0, 0, 0, 1'b1));
    send_pixel(make_pixel(16'hFFFF, 0, 0, 0, 0, 1'b1));
    send_pixel(make_pixel(16'hFFFF, 100, 100, 100, 100, 1'b0));
    send_pixel(make_pixel(16'h1234, 0, 0, -50, 50, 1'b1));
    send_pixel(make_pixel(16'h1234, 0, 0, 50, -50, 1'b1));
    send_pixel(make_pixel(16'h8000, -10, 10, 0, 0, 1'b1));
    send_pixel(make_pixel(16'hFFFF, -524288, 524287, -524288, 524287, 1'b1));
    send_pixel(make_pixel(16'hFFFF, 524287, -524288, 524287, -524288, 1'b1));
    send_pixel(make_pixel(16'h5555, 524287, -524288, -524288, 524287, 1'b0));
    send_pixel(make_pixel(16'hAAAA, 200, 900, -300, 400, 1'b1));
    set_config(16'd10000, 16'd0, 16'd32768, 16'd240, 16'd240);
    // Steep slopes facing toward and away from a low sun.
    send_pixel(make_pixel(16'hFFFF, 0, 20000, 0, 0, 1'b1));
    send_pixel(make_pixel(16'hFFFF, 20000, 0, 0, 0, 1'b1));
    send_pixel(make_pixel(16'd1, 0, 2000, 0, 0, 1'b1));
    send_pixel(make_pixel(16'hFFFF, 0, 300, 0, 0, 1'b1));
    set_config(16'd16383, 16'd65535, 16'd16384, 16'd0, 16'd0);
    send_pixel(make_pixel(16'hFFFF, 0, 0, 0, 0, 1'b1));
    send_pixel(make_pixel(16'h0F0F, 1, 0, 0, 1, 1'b1));
    set_config(16'd16383, 16'd3000, 16'd0, 16'd1, 16'd1);
    send_pixel(make_pixel(16'hF0F0, 0, 0, 0, 0, 1'b1));
    send_pixel(make_pixel(16'hF0F0, 0, 3, 0, 0, 1'b1));
    set_config(16'd12868, 16'd51471, 16'd65535, 16'd65535, 16'd65535);
    send_pixel(make_pixel(16'hFFFF, 0, 0, 0, 0, 1'b1));
    send_pixel(make_pixel(16'hFFFF, -4000, 4000, 100, 0, 1'b1));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = $urandom_range(0, 2) == 0;
      send_pixel(random_pixel());
    end
    burst = 0;
  endtask

  task automatic test_settings;
    set_config(16'd0, 16'd0, 16'd16384, 16'd240, 16'd240);
    test_random(100);
    set_config(16'd4000, 16'd20000, 16'd24576, 16'd240, 16'd480);
    test_random(100);
    set_config(16'd12868, 16'd51471, 16'd32768, 16'd65535, 16'd1);
    test_random(80);
    set_config(16'd0, 16'd0, 16'd0, 16'd1, 16'd65535);
    test_random(60);
    set_config(16'd16383, 16'd65535, 16'd65535, 16'd0, 16'd0);
    test_random(40);
    set_config(16'($urandom_range(0, 12868)), 16'($urandom_range(0, 51471)),
               16'($urandom_range(0, 32768)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)));
    test_random(80);
  endtask

  task automatic test_backpressure;
    set_config(16'd6000, 16'd30000, 16'd12000, 16'd240, 16'd240);
    hold_req = 1;
    burst = 1;
    for (int i = 0; i < 150; i++) send_pixel(random_pixel());
    burst = 0;
    drain();
  endtask

  initial begin
    out_gap = 0;
    hold_left = 0;
    hold_req = 0;
    burst = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = 0;
    m_axis_tready = 0;
    cfg_valid = 0;
    cfg_index = mtc_pkg::CFG_ZENITH;
    cfg_data = '0;
    zenith = 0;
    azimuth = 0;
    k_exp = 16384;
    step_x = 240;
    step_y = 240;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_settings();
    test_backpressure();
    drain();
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
